// ----- rtl/itpp_pkg.sv -----
// Shared constants for the trace packet parser.
// No dependencies; compile before every other file of the block.
package itpp_pkg;

    // Event kinds on the result channel
    localparam logic [2:0] KIND_SYNC      = 3'd0;
    localparam logic [2:0] KIND_OVERFLOW  = 3'd1;
    localparam logic [2:0] KIND_TIMESTAMP = 3'd2;
    localparam logic [2:0] KIND_INSTR     = 3'd3;
    localparam logic [2:0] KIND_HW        = 3'd4;

    // Header codes and packet limits
    localparam logic [7:0] HDR_OVERFLOW   = 8'h70;
    localparam logic [3:0] NIB_TIMESTAMP  = 4'h0;
    localparam logic [3:0] NIB_EXT_A      = 4'h4;
    localparam logic [3:0] NIB_EXT_B      = 4'h8;
    localparam logic [3:0] NIB_EXT_C      = 4'hc;
    localparam logic [2:0] SYNC_ZEROS     = 3'd6;
    localparam logic [2:0] MAX_CONT_BYTES = 3'd4;

    // Payload size codes in header bits 1:0
    localparam logic [1:0] SIZE_ONE       = 2'd1;
    localparam logic [1:0] SIZE_TWO       = 2'd2;

endpackage

// ----- rtl/itpp_decode.sv -----
// Packet state machine and result register of the trace packet parser.
// Depends on itpp_pkg.
module itpp_decode (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_valid,
    input  logic [7:0] step_byte,
    output logic       step_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_kind,
    output logic [7:0] m_event_tag,
    output logic [31:0] m_event_value
);
    import itpp_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_ZEROS   = 3'd1,
        MODE_TSLONG  = 3'd2,
        MODE_EXT     = 3'd3,
        MODE_PAYLOAD = 3'd4
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [2:0]  zero_run_reg, zero_run_next;
    logic [7:0]  header_reg, header_next;
    logic [2:0]  index_reg, index_next;
    logic [2:0]  length_reg, length_next;
    logic [31:0] accum_reg, accum_next;

    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [7:0]  out_tag_reg;
    logic [31:0] out_value_reg;

    logic        fire;
    logic        take_hdr;
    logic        ev_fire;
    logic [2:0]  ev_kind;
    logic [7:0]  ev_tag;
    logic [31:0] ev_value;
    logic [2:0]  zr_inc;
    logic [2:0]  idx_inc;
    logic [4:0]  ts_shift;
    logic [31:0] ts_accum;
    logic [31:0] pl_accum;
    logic [3:0]  nib;

    // Advance when the result register is free or drains this cycle
    assign step_ready = !out_valid_reg || m_ready;
    assign fire       = step_valid && step_ready;

    assign zr_inc   = zero_run_reg + 3'd1;
    assign idx_inc  = index_reg + 3'd1;
    assign ts_shift = 5'(index_reg[1:0]) * 5'd7;
    assign ts_accum = accum_reg | ({25'd0, step_byte[6:0]} << ts_shift);
    assign pl_accum = accum_reg | ({24'd0, step_byte} << {index_reg[1:0], 3'b000});
    assign nib      = step_byte[3:0];

    // Next state and event for one trace byte
    always_comb begin
        mode_next     = mode_reg;
        zero_run_next = zero_run_reg;
        header_next   = header_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        accum_next    = accum_reg;
        take_hdr      = 1'b0;
        ev_fire       = 1'b0;
        ev_kind       = KIND_SYNC;
        ev_tag        = 8'd0;
        ev_value      = 32'd0;

        unique case (mode_reg)
            MODE_ZEROS: begin
                if (step_byte != 8'd0) begin
                    zero_run_next = 3'd0;
                    take_hdr      = 1'b1;
                end else if (zr_inc >= SYNC_ZEROS) begin
                    zero_run_next = 3'd0;
                    mode_next     = MODE_IDLE;
                    ev_fire       = 1'b1;
                    ev_kind       = KIND_SYNC;
                end else begin
                    zero_run_next = zr_inc;
                end
            end
            MODE_TSLONG: begin
                accum_next = ts_accum;
                index_next = idx_inc;
                if (!step_byte[7] || idx_inc >= MAX_CONT_BYTES) begin
                    mode_next = MODE_IDLE;
                    ev_fire   = 1'b1;
                    ev_kind   = KIND_TIMESTAMP;
                    ev_tag    = {6'd0, header_reg[5:4]};
                    ev_value  = ts_accum;
                end
            end
            MODE_EXT: begin
                index_next = idx_inc;
                if (!step_byte[7] || idx_inc >= MAX_CONT_BYTES) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_PAYLOAD: begin
                accum_next = pl_accum;
                index_next = idx_inc;
                if (idx_inc >= length_reg) begin
                    mode_next = MODE_IDLE;
                    ev_fire   = 1'b1;
                    ev_kind   = header_reg[2] ? KIND_HW : KIND_INSTR;
                    ev_tag    = header_reg;
                    ev_value  = pl_accum;
                end
            end
            default: begin
                take_hdr = 1'b1;
            end
        endcase

        // Classify a header byte
        if (take_hdr) begin
            mode_next  = MODE_IDLE;
            index_next = 3'd0;
            accum_next = 32'd0;
            if (step_byte == 8'd0) begin
                mode_next     = MODE_ZEROS;
                zero_run_next = 3'd1;
            end else if (step_byte == HDR_OVERFLOW) begin
                ev_fire = 1'b1;
                ev_kind = KIND_OVERFLOW;
            end else if (nib == NIB_TIMESTAMP) begin
                if (!step_byte[7]) begin
                    ev_fire  = 1'b1;
                    ev_kind  = KIND_TIMESTAMP;
                    ev_value = {29'd0, step_byte[6:4]};
                end else begin
                    header_next = step_byte;
                    mode_next   = MODE_TSLONG;
                end
            end else if (nib == NIB_EXT_A || nib == NIB_EXT_B || nib == NIB_EXT_C) begin
                if (step_byte[7]) begin
                    mode_next = MODE_EXT;
                end
            end else begin
                header_next = step_byte;
                mode_next   = MODE_PAYLOAD;
                case (step_byte[1:0])
                    SIZE_ONE: length_next = 3'd1;
                    SIZE_TWO: length_next = 3'd2;
                    default:  length_next = 3'd4;
                endcase
            end
        end
    end

    // Hold parse state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            zero_run_reg  <= 3'd0;
            header_reg    <= 8'd0;
            index_reg     <= 3'd0;
            length_reg    <= 3'd0;
            accum_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                mode_reg     <= mode_next;
                zero_run_reg <= zero_run_next;
                header_reg   <= header_next;
                index_reg    <= index_next;
                length_reg   <= length_next;
                accum_reg    <= accum_next;
            end
            if (fire && ev_fire) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= ev_kind;
                out_tag_reg   <= ev_tag;
                out_value_reg <= ev_value;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_kind_reg;
    assign m_event_tag   = out_tag_reg;
    assign m_event_value = out_value_reg;

endmodule

// ----- rtl/itm_trace_packet_parser.sv -----
// Top level of the trace packet parser: input register and decoder.
// Depends on itpp_decode (and through it on itpp_pkg).
//
//   channel   direction  ports                                   content
//   s_        in         s_valid s_ready s_trace_byte            one trace byte
//   m_        out        m_valid m_ready m_event_kind/tag/value  one decoded event
//
// One byte is taken per cycle while s_ready is high; an event shows on m_valid once
// its last byte has passed the input register, then the result register.
// Reset (aresetn low, synchronous) returns the parser to waiting for a header.
// A stalled result holds in its register while one more byte waits in the input
// register; s_ready drops only when both are full.
module itm_trace_packet_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_trace_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [7:0]  m_event_tag,
    output logic [31:0] m_event_value
);
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step_ready;

    assign s_ready = !in_valid_reg || step_ready;

    // Load a request or drain the input register into the decoder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_trace_byte;
            end else if (step_ready) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    itpp_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_valid    (in_valid_reg),
        .step_byte     (in_byte_reg),
        .step_ready    (step_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_event_tag   (m_event_tag),
        .m_event_value (m_event_value)
    );

endmodule

// ----- rtl/itpp_checker.sv -----
// Port-level checks for the trace packet parser, bound to the top level.
// Depends on itpp_pkg and itm_trace_packet_parser.
module itpp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_event_kind,
    input logic [7:0]  m_event_tag,
    input logic [31:0] m_event_value
);
    import itpp_pkg::*;

    // A stalled result keeps its kind, tag and value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_value)
            && $stable(m_event_tag) && $stable(m_event_kind))
        else $error("result changed while stalled");

    // Sync and overflow carry nothing
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_SYNC || m_event_kind == KIND_OVERFLOW)
            |-> m_event_tag == 8'd0 && m_event_value == 32'd0)
        else $error("sync or overflow with nonzero fields");

    // Timestamps have a 2-bit code and at most 28 value bits
    a_ts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_TIMESTAMP
            |-> m_event_tag[7:2] == 6'd0 && m_event_value[31:28] == 4'd0)
        else $error("timestamp out of range");

    // Source kind follows header bit 2, and size code is never zero
    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_INSTR || m_event_kind == KIND_HW)
            |-> m_event_tag[1:0] != 2'd0
                && (m_event_tag[2] == (m_event_kind == KIND_HW)))
        else $error("source packet header mismatch");

    // Short payloads leave upper bytes clear
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_INSTR || m_event_kind == KIND_HW)
            && m_event_tag[1:0] != 2'd3
            |-> m_event_value[31:16] == 16'd0
                && (m_event_tag[1:0] != SIZE_ONE || m_event_value[15:8] == 8'd0))
        else $error("payload wider than its size code");

endmodule

bind itm_trace_packet_parser itpp_checker u_itpp_checker (.*);
